FILE: sv/awmd_pkg.sv
// ----------------------------------------------------------------------------
// awmd_pkg
// Shared types and constants of the window motion detector: register map,
// register widths and the packed register set.
// ----------------------------------------------------------------------------
`default_nettype none

package awmd_pkg;

   localparam int FREQ_W      = 5;
   localparam int THRESH_W    = 21;
   localparam int NOISE_W     = 18;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 21;
   localparam int RSP_TDATA_W = 8;

   localparam logic [NOISE_W-1:0] NOISE_RESET = NOISE_W'(10);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FREQ_THRESHOLD = 3'd0,
      REG_X_THRESHOLD    = 3'd1,
      REG_Y_THRESHOLD    = 3'd2,
      REG_Z_THRESHOLD    = 3'd3,
      REG_NOISE_LEVEL    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [FREQ_W-1:0]   freq_threshold;
      logic [THRESH_W-1:0] x_threshold;
      logic [THRESH_W-1:0] y_threshold;
      logic [THRESH_W-1:0] z_threshold;
      logic [NOISE_W-1:0]  noise_level;
   } cfg_type;

endpackage

`default_nettype wire

FILE: sv/accel_window_motion_detect.sv
// ----------------------------------------------------------------------------
// accel_window_motion_detect
// Sliding window motion detector for a three-axis accelerometer stream.
//
//   channel  | direction | contents
//   req_*    | in        | tdata: x_sample, y_sample, z_sample
//   rsp_*    | out       | tdata: detected
//   csr_*    | in        | register writes, no read-back
//
// One word is accepted per cycle while the result side does not stall; its
// result passes the delta, window and result registers behind the input register.
// Throughput is set by the delta ring, one write and one read per cycle.
// Synchronous reset clears the pipeline and window sums and sets the registers
// to their reset values; the ring contents are left as they are and need no clearing pass.
// A stalled result holds every stage that is full; empty stages still fill.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_window_motion_detect #(
   parameter int WINDOW_LEN  = 20,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // x_sample, y_sample, z_sample, zero fill
   input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // detected, zero fill
   output logic [awmd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_wr_en,
   input  logic [awmd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [awmd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import awmd_pkg::*;

   localparam int SB    = SAMPLE_BITS;
   localparam int CNT_W = $clog2(WINDOW_LEN);
   localparam int SUM_W = SB + CNT_W;
   localparam logic [FREQ_W-1:0] FREQ_SAT = FREQ_W'(WINDOW_LEN - 1);

   cfg_type cfg_ff, cfg_in;

   logic          d_valid, d_ready, d_pair;
   logic [SB-1:0] d_dx, d_dy, d_dz;
   logic          w_valid, w_ready, w_have_pair;
   logic [CNT_W-1:0] w_cnt;
   logic [SUM_W-1:0] w_sum_x, w_sum_y, w_sum_z;
   logic          detected;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_FREQ_THRESHOLD: begin
               // saturate to the number of pairs in the window
               if (32'(csr_wdata[FREQ_W-1:0]) >= 32'(WINDOW_LEN)) begin
                  cfg_in.freq_threshold = FREQ_SAT;
               end else begin
                  cfg_in.freq_threshold = csr_wdata[FREQ_W-1:0];
               end
            end
            REG_X_THRESHOLD: cfg_in.x_threshold = csr_wdata[THRESH_W-1:0];
            REG_Y_THRESHOLD: cfg_in.y_threshold = csr_wdata[THRESH_W-1:0];
            REG_Z_THRESHOLD: cfg_in.z_threshold = csr_wdata[THRESH_W-1:0];
            REG_NOISE_LEVEL: cfg_in.noise_level = csr_wdata[NOISE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.freq_threshold <= FREQ_SAT;
         cfg_ff.x_threshold    <= '0;
         cfg_ff.y_threshold    <= '0;
         cfg_ff.z_threshold    <= '0;
         cfg_ff.noise_level    <= NOISE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   awmd_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_x      (req_tdata[SB-1:0]),
      .in_y      (req_tdata[2*SB-1:SB]),
      .in_z      (req_tdata[3*SB-1:2*SB]),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_pair  (d_pair),
      .out_dx    (d_dx),
      .out_dy    (d_dy),
      .out_dz    (d_dz)
   );

   awmd_window #(
      .WINDOW_LEN  (WINDOW_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_window (
      .clock           (clock),
      .reset           (reset),
      .noise_level     (cfg_ff.noise_level),
      .in_valid        (d_valid),
      .in_ready        (d_ready),
      .in_pair         (d_pair),
      .in_dx           (d_dx),
      .in_dy           (d_dy),
      .in_dz           (d_dz),
      .out_valid       (w_valid),
      .out_ready       (w_ready),
      .out_have_pair   (w_have_pair),
      .out_noisy_count (w_cnt),
      .out_sum_x       (w_sum_x),
      .out_sum_y       (w_sum_y),
      .out_sum_z       (w_sum_z)
   );

   awmd_judge #(
      .WINDOW_LEN  (WINDOW_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_judge (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .in_valid       (w_valid),
      .in_ready       (w_ready),
      .in_have_pair   (w_have_pair),
      .in_noisy_count (w_cnt),
      .in_sum_x       (w_sum_x),
      .in_sum_y       (w_sum_y),
      .in_sum_z       (w_sum_z),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_detected   (detected)
   );

   assign rsp_tdata = RSP_TDATA_W'(detected);

endmodule

`default_nettype wire

FILE: sv/awmd_front.sv
// ----------------------------------------------------------------------------
// awmd_front
// Input register and pair delta stage: biases each sample to an ordered
// unsigned value and forms per-axis absolute differences to the previous one.
// ----------------------------------------------------------------------------
`default_nettype none

module awmd_front #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [SAMPLE_BITS-1:0] in_x,
   input  logic [SAMPLE_BITS-1:0] in_y,
   input  logic [SAMPLE_BITS-1:0] in_z,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic                   out_pair,
   output logic [SAMPLE_BITS-1:0] out_dx,
   output logic [SAMPLE_BITS-1:0] out_dy,
   output logic [SAMPLE_BITS-1:0] out_dz
);
   import awmd_pkg::*;

   localparam int SB = SAMPLE_BITS;

   logic          s1_valid_ff, s1_valid_in;
   logic [SB-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic          s2_valid_ff, s2_valid_in;
   logic          s2_pair_ff;
   logic [SB-1:0] s2_dx_ff, s2_dy_ff, s2_dz_ff;
   logic          seen_ff;
   logic [SB-1:0] last_x_ff, last_y_ff, last_z_ff;
   logic          s2_take, s1_take;

   function automatic logic [SB-1:0] biased(input logic [SB-1:0] v);
      biased = {~v[SB-1], v[SB-2:0]};
   endfunction

   function automatic logic [SB-1:0] abs_diff(input logic [SB-1:0] a,
                                              input logic [SB-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   assign s2_take  = s1_valid_ff && (!s2_valid_ff || out_ready);
   assign s1_take  = in_valid && in_ready;
   assign in_ready = !s1_valid_ff || s2_take;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_take) begin
         s1_valid_in = 1'b1;
      end else if (s2_take) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s2_take) begin
         s2_valid_in = 1'b1;
      end else if (out_ready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         seen_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (s2_take) begin
            seen_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_x_ff <= biased(in_x);
         s1_y_ff <= biased(in_y);
         s1_z_ff <= biased(in_z);
      end
      if (s2_take) begin
         s2_pair_ff <= seen_ff;
         s2_dx_ff   <= abs_diff(s1_x_ff, last_x_ff);
         s2_dy_ff   <= abs_diff(s1_y_ff, last_y_ff);
         s2_dz_ff   <= abs_diff(s1_z_ff, last_z_ff);
         last_x_ff  <= s1_x_ff;
         last_y_ff  <= s1_y_ff;
         last_z_ff  <= s1_z_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_pair  = s2_pair_ff;
   assign out_dx    = s2_dx_ff;
   assign out_dy    = s2_dy_ff;
   assign out_dz    = s2_dz_ff;

endmodule

`default_nettype wire

FILE: sv/awmd_window.sv
// ----------------------------------------------------------------------------
// awmd_window
// Delta ring and running window state: once the ring is full, the oldest pair
// leaves the sums and the noisy count as the newest pair enters.
// ----------------------------------------------------------------------------
`default_nettype none

module awmd_window #(
   parameter int WINDOW_LEN  = 20,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [awmd_pkg::NOISE_W-1:0]            noise_level,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic                                    in_pair,
   input  logic [SAMPLE_BITS-1:0]                  in_dx,
   input  logic [SAMPLE_BITS-1:0]                  in_dy,
   input  logic [SAMPLE_BITS-1:0]                  in_dz,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic                                    out_have_pair,
   output logic [$clog2(WINDOW_LEN)-1:0]           out_noisy_count,
   output logic [SAMPLE_BITS+$clog2(WINDOW_LEN)-1:0] out_sum_x,
   output logic [SAMPLE_BITS+$clog2(WINDOW_LEN)-1:0] out_sum_y,
   output logic [SAMPLE_BITS+$clog2(WINDOW_LEN)-1:0] out_sum_z
);
   import awmd_pkg::*;

   localparam int SB     = SAMPLE_BITS;
   localparam int PAIRS  = WINDOW_LEN - 1;
   localparam int PTR_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int CNT_W  = $clog2(WINDOW_LEN);
   localparam int SUM_W  = SB + CNT_W;
   localparam int ENT_W  = 3 * SB + 1;
   localparam int DSUM_W = SB + 2;
   localparam int NZ_W   = (DSUM_W > NOISE_W) ? DSUM_W : NOISE_W;

   logic [ENT_W-1:0] ring_mem [PAIRS];
   logic [ENT_W-1:0] rd_ff;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] pairs_ff, pairs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in, sum_z_ff, sum_z_in;
   logic             valid_ff, valid_in;
   logic             take, update, full, noisy, drop_noisy;
   logic [DSUM_W-1:0] dsum;
   logic [ENT_W-1:0] wr_data;
   logic [SUM_W-1:0] old_x, old_y, old_z;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign update   = take && in_pair;
   assign full     = (pairs_ff == CNT_W'(PAIRS));

   assign dsum  = DSUM_W'(in_dx) + DSUM_W'(in_dy) + DSUM_W'(in_dz);
   assign noisy = NZ_W'(dsum) > NZ_W'(noise_level);
   assign wr_data = {noisy, in_dz, in_dy, in_dx};

   // oldest pair only counts once the ring is full
   assign old_x = full ? SUM_W'(rd_ff[SB-1:0])      : '0;
   assign old_y = full ? SUM_W'(rd_ff[2*SB-1:SB])   : '0;
   assign old_z = full ? SUM_W'(rd_ff[3*SB-1:2*SB]) : '0;
   assign drop_noisy = full && rd_ff[3*SB] && (cnt_ff != '0);

   always_comb begin
      ptr_in   = ptr_ff;
      pairs_in = pairs_ff;
      cnt_in   = cnt_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      sum_z_in = sum_z_ff;
      if (update) begin
         ptr_in   = (ptr_ff == PTR_W'(PAIRS - 1)) ? '0 : ptr_ff + PTR_W'(1);
         pairs_in = full ? pairs_ff : pairs_ff + CNT_W'(1);
         cnt_in   = cnt_ff - CNT_W'(drop_noisy) + CNT_W'(noisy);
         sum_x_in = sum_x_ff - old_x + SUM_W'(in_dx);
         sum_y_in = sum_y_ff - old_y + SUM_W'(in_dy);
         sum_z_in = sum_z_ff - old_z + SUM_W'(in_dz);
      end
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ptr_ff   <= '0;
         pairs_ff <= '0;
         cnt_ff   <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sum_z_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         ptr_ff   <= ptr_in;
         pairs_ff <= pairs_in;
         cnt_ff   <= cnt_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         sum_z_ff <= sum_z_in;
      end
   end

   // read data always holds the entry at the next write address
   always_ff @(posedge clock) begin
      if (update) begin
         ring_mem[ptr_ff] <= wr_data;
      end
      if (update && (ptr_in == ptr_ff)) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= ring_mem[ptr_in];
      end
   end

   assign out_valid       = valid_ff;
   assign out_have_pair   = (pairs_ff != '0);
   assign out_noisy_count = cnt_ff;
   assign out_sum_x       = sum_x_ff;
   assign out_sum_y       = sum_y_ff;
   assign out_sum_z       = sum_z_ff;

endmodule

`default_nettype wire

FILE: sv/awmd_judge.sv
// ----------------------------------------------------------------------------
// awmd_judge
// Threshold compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module awmd_judge #(
   parameter int WINDOW_LEN  = 20,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  awmd_pkg::cfg_type                         cfg,
   input  logic                                      in_valid,
   output logic                                      in_ready,
   input  logic                                      in_have_pair,
   input  logic [$clog2(WINDOW_LEN)-1:0]             in_noisy_count,
   input  logic [SAMPLE_BITS+$clog2(WINDOW_LEN)-1:0] in_sum_x,
   input  logic [SAMPLE_BITS+$clog2(WINDOW_LEN)-1:0] in_sum_y,
   input  logic [SAMPLE_BITS+$clog2(WINDOW_LEN)-1:0] in_sum_z,
   output logic                                      out_valid,
   input  logic                                      out_ready,
   output logic                                      out_detected
);
   import awmd_pkg::*;

   localparam int CNT_W = $clog2(WINDOW_LEN);
   localparam int SUM_W = SAMPLE_BITS + CNT_W;
   localparam int CW    = (CNT_W > FREQ_W) ? CNT_W : FREQ_W;
   localparam int TW    = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;

   logic valid_ff, valid_in;
   logic detected_ff;
   logic take, hit;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   assign hit = in_have_pair &&
                (CW'(in_noisy_count) >= CW'(cfg.freq_threshold)) &&
                (TW'(in_sum_x) >= TW'(cfg.x_threshold)) &&
                (TW'(in_sum_y) >= TW'(cfg.y_threshold)) &&
                (TW'(in_sum_z) >= TW'(cfg.z_threshold));

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         detected_ff <= hit;
      end
   end

   assign out_valid    = valid_ff;
   assign out_detected = detected_ff;

endmodule

`default_nettype wire

FILE: sv/awmd_checker.sv
// ----------------------------------------------------------------------------
// awmd_checker
// Port-level checks on the motion detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module awmd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [awmd_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import awmd_pkg::*;

   // pipeline comes out of reset empty and ready
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("pipeline not empty after reset");

   // a free result register lets every stage move, so input is taken
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled while result side is free");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result word changed");

   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_TDATA_W-1:1] == '0))
      else $error("result fill bits not zero");

endmodule

bind accel_window_motion_detect awmd_checker u_awmd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

FILE: bench/tb_accel_window_motion_detect.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_accel_window_motion_detect
// Self-checking bench for the window motion detector. A behavioural copy of
// the window (pair steps, running axis sums, noisy pair count) predicts the
// detected flag of every accepted sample word; results are compared in order
// while both stream sides idle and stall at random. Directed checks cover the
// short window, the noise boundary, full-swing samples and register masking,
// followed by randomised phases of still and moving bursts under changing
// thresholds.
// ----------------------------------------------------------------------------

module tb_accel_window_motion_detect;
   import awmd_pkg::*;

   localparam int WINDOW_LEN     = 20;
   localparam int SAMPLE_BITS    = 16;
   localparam int PAIRS          = WINDOW_LEN - 1;
   localparam int REQ_TDATA_W    = ((3*SAMPLE_BITS+7)/8)*8;
   localparam int SAMPLE_MAX     = (1 << (SAMPLE_BITS-1)) - 1;
   localparam int SAMPLE_MIN     = -(1 << (SAMPLE_BITS-1));
   localparam int FULL_SWING_SUM = PAIRS * ((1 << SAMPLE_BITS) - 1);
   localparam int THRESH_MAX     = (1 << THRESH_W) - 1;
   localparam int GAP_PERCENT    = 10;
   localparam int RESET_CYCLES   = 8;
   localparam int SETTLE_CYCLES  = 10;
   localparam int DRAIN_LIMIT    = 5000;
   localparam int REPORT_LIMIT   = 10;
   localparam int PHASE_WORDS    = 100;

   localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_W-1:0]    req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]    rsp_tdata;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   bit no_gaps = 1'b0;
   int fail_count = 0;
   bit detect_expected [$];

   // register mirror and window state of the predictor
   cfg_type                 cfg;
   logic [SAMPLE_BITS-1:0]  prev_level [3];
   logic [SAMPLE_BITS-1:0]  step_ring [PAIRS][3];
   bit                      noisy_ring [PAIRS];
   logic [THRESH_W-1:0]     axis_sum [3];
   int                      held = 0;
   int                      ring_pos = 0;
   int                      noisy_pairs = 0;

   accel_window_motion_detect #(
      .WINDOW_LEN  (WINDOW_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT);
   end

   function automatic void store_reg(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_FREQ_THRESHOLD: cfg.freq_threshold = (val[FREQ_W-1:0] >= WINDOW_LEN) ?
                                FREQ_W'(WINDOW_LEN-1) : val[FREQ_W-1:0];
         REG_X_THRESHOLD:    cfg.x_threshold = val[THRESH_W-1:0];
         REG_Y_THRESHOLD:    cfg.y_threshold = val[THRESH_W-1:0];
         REG_Z_THRESHOLD:    cfg.z_threshold = val[THRESH_W-1:0];
         REG_NOISE_LEVEL:    cfg.noise_level = val[NOISE_W-1:0];
         default: ;
      endcase
   endfunction

   // advances the window by one sample and returns its detected flag
   function automatic bit predict_motion(input logic [3*SAMPLE_BITS-1:0] word);
      logic [SAMPLE_BITS-1:0] level [3];
      logic [SAMPLE_BITS-1:0] step [3];
      logic [NOISE_W+1:0]     total;
      bit                     noisy;
      total = '0;
      for (int a = 0; a < 3; a++) begin
         // offset binary keeps the order of signed samples
         level[a] = word[a*SAMPLE_BITS +: SAMPLE_BITS] ^ SIGN_FLIP;
         step[a]  = (level[a] > prev_level[a]) ? level[a] - prev_level[a] :
                                                 prev_level[a] - level[a];
         total += step[a];
      end
      noisy = total > cfg.noise_level;
      if (held >= 1) begin
         if (held - 1 >= PAIRS) begin
            // oldest pair leaves before the newest enters
            for (int a = 0; a < 3; a++) axis_sum[a] -= step_ring[ring_pos][a];
            if (noisy_ring[ring_pos] && noisy_pairs > 0) noisy_pairs--;
         end
         for (int a = 0; a < 3; a++) begin
            step_ring[ring_pos][a] = step[a];
            axis_sum[a] += step[a];
         end
         noisy_ring[ring_pos] = noisy;
         if (noisy) noisy_pairs++;
         ring_pos = (ring_pos + 1) % PAIRS;
      end
      if (held < WINDOW_LEN) held++;
      prev_level = level;
      return held >= 2 && noisy_pairs >= cfg.freq_threshold &&
             axis_sum[0] >= cfg.x_threshold && axis_sum[1] >= cfg.y_threshold &&
             axis_sum[2] >= cfg.z_threshold;
   endfunction

   function automatic logic [3*SAMPLE_BITS-1:0] pack_sample(input int x, input int y,
                                                            input int z);
      return {SAMPLE_BITS'(z), SAMPLE_BITS'(y), SAMPLE_BITS'(x)};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_threshold();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return CSR_DATA_W'(THRESH_MAX);
         2: return CSR_DATA_W'($urandom_range(0, 2000));
         3: return CSR_DATA_W'($urandom_range(0, 100000));
         4: return CSR_DATA_W'($urandom_range(100000, 600000));
         default: return CSR_DATA_W'($urandom_range(0, FULL_SWING_SUM));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_noise();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return CSR_DATA_W'($urandom_range(0, 300));
         3: return CSR_DATA_W'($urandom_range(0, 20000));
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   task automatic check_detect(input logic got);
      bit want;
      if (detect_expected.size() == 0) begin
         note_failure($sformatf("unexpected result word at %0t: detected %b", $time, got));
      end else begin
         want = detect_expected.pop_front();
         if (got !== want)
            note_failure($sformatf("detected mismatch at %0t: expected %0b, got %b",
                                   $time, want, got));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_detect(rsp_tdata[0]);
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_sample(input logic [3*SAMPLE_BITS-1:0] word);
      while (!no_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_TDATA_W'({$urandom(), $urandom()});
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(word);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      detect_expected.push_back(predict_motion(word));
      @(negedge clock);
   endtask

   // write enable stays high between back-to-back writes until csr_done lowers it
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      store_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic csr_done();
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] freq, input logic [CSR_DATA_W-1:0] x,
                            input logic [CSR_DATA_W-1:0] y, input logic [CSR_DATA_W-1:0] z,
                            input logic [CSR_DATA_W-1:0] noise);
      write_reg(REG_FREQ_THRESHOLD, freq);
      write_reg(REG_X_THRESHOLD, x);
      write_reg(REG_Y_THRESHOLD, y);
      write_reg(REG_Z_THRESHOLD, z);
      write_reg(REG_NOISE_LEVEL, noise);
      csr_done();
   endtask

   task automatic wait_drained();
      int waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (detect_expected.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // first sample has no pair, the second one already can detect
   task automatic test_short_window();
      write_reg(REG_FREQ_THRESHOLD, '0);
      csr_done();
      send_sample(pack_sample(0, 0, 0));
      send_sample(pack_sample(0, 0, 0));
      wait_drained();
   endtask

   // summed step of exactly the reset noise level is quiet, one more is noisy
   task automatic test_noise_edge();
      write_reg(REG_FREQ_THRESHOLD, CSR_DATA_W'(1));
      csr_done();
      send_sample(pack_sample(3, 4, -3));
      send_sample(pack_sample(6, 8, -7));
      wait_drained();
   endtask

   // full-swing pairs fill the window up to the largest sums, then a flat pair
   task automatic test_extremes();
      configure(CSR_DATA_W'(WINDOW_LEN), CSR_DATA_W'(FULL_SWING_SUM),
                CSR_DATA_W'(FULL_SWING_SUM), CSR_DATA_W'(FULL_SWING_SUM), '0);
      for (int i = 0; i < WINDOW_LEN; i++) begin
         if (i % 2 == 0) send_sample(pack_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX));
         else send_sample(pack_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN));
      end
      send_sample(pack_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN));
      wait_drained();
   endtask

   // unused indexes are ignored, bits above a register's width are dropped
   task automatic test_register_writes();
      for (int idx = int'(REG_NOISE_LEVEL) + 1; idx < (1 << CSR_INDEX_W); idx++)
         write_reg(CSR_INDEX_W'(idx), CSR_DATA_W'($urandom));
      write_reg(REG_FREQ_THRESHOLD, 21'h1FFFE3);
      write_reg(REG_X_THRESHOLD, 21'h000100);
      write_reg(REG_Y_THRESHOLD, 21'h000080);
      write_reg(REG_Z_THRESHOLD, 21'h000040);
      write_reg(REG_NOISE_LEVEL, 21'h1C0005);
      csr_done();
      for (int i = 0; i < 6; i++)
         send_sample(pack_sample($urandom_range(0, 200), -int'($urandom_range(0, 200)),
                                 $urandom_range(0, 60)));
      wait_drained();
   endtask

   // bursts around a random centre: still, moderate or full-range movement
   task automatic test_random_phase(input int words, input bit gapless, input bit new_cfg);
      int                      amp;
      int                      burst;
      int                      left;
      int                      offset;
      logic [SAMPLE_BITS-1:0]  centre [3];
      logic [3*SAMPLE_BITS-1:0] word;
      if (new_cfg)
         configure(($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom) :
                   CSR_DATA_W'($urandom_range(0, 24)),
                   random_threshold(), random_threshold(), random_threshold(),
                   random_noise());
      no_gaps = gapless;
      left = words;
      while (left > 0) begin
         case ($urandom_range(0, 2))
            0: amp = $urandom_range(0, 20);
            1: amp = $urandom_range(100, 3000);
            default: amp = SAMPLE_MAX;
         endcase
         for (int a = 0; a < 3; a++) centre[a] = SAMPLE_BITS'($urandom);
         burst = $urandom_range(1, 30);
         while (burst > 0 && left > 0) begin
            for (int a = 0; a < 3; a++) begin
               offset = int'($urandom_range(0, 2*amp)) - amp;
               word[a*SAMPLE_BITS +: SAMPLE_BITS] = centre[a] + SAMPLE_BITS'(offset);
            end
            send_sample(word);
            burst--;
            left--;
         end
      end
      wait_drained();
      no_gaps = 1'b0;
   endtask

   initial begin
      cfg.freq_threshold = FREQ_W'(WINDOW_LEN-1);
      cfg.x_threshold    = '0;
      cfg.y_threshold    = '0;
      cfg.z_threshold    = '0;
      cfg.noise_level    = NOISE_RESET;
      for (int a = 0; a < 3; a++) begin
         prev_level[a] = '0;
         axis_sum[a]   = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_short_window();
      test_noise_edge();
      test_extremes();
      test_register_writes();

      configure('0, '0, '0, '0, '0);
      test_random_phase(PHASE_WORDS, 1'b0, 1'b0);
      for (int p = 0; p < 7; p++) test_random_phase(PHASE_WORDS, p == 3, 1'b1);
      configure('1, '1, '1, '1, '1);
      test_random_phase(PHASE_WORDS, 1'b0, 1'b0);

      wait_drained();
      if (fail_count == 0 && detect_expected.size() == 0) begin
         $display("tb_accel_window_motion_detect OK");
      end else begin
         $display("tb_accel_window_motion_detect NOT OK");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb_accel_window_motion_detect NOT OK");
      $finish;
   end

endmodule

FILE: sim.f
sv/awmd_pkg.sv
sv/awmd_front.sv
sv/awmd_window.sv
sv/awmd_judge.sv
sv/accel_window_motion_detect.sv
sv/awmd_checker.sv
bench/tb_accel_window_motion_detect.sv
